// ----- rtl/hbsp_pkg.sv -----
// shared types and constants for the h-bridge soft pwm driver
package hbsp_pkg;

    // number of h-bridge motors driven by the block
    localparam int NUM_MOTORS = 2;
    // motors that appear in the fixed-width result fields
    localparam int OUT_MOTORS = (NUM_MOTORS < 2) ? NUM_MOTORS : 2;

    localparam int STEP_W = 6;
    localparam int DUTY_W = 6;
    localparam int CFG_IDX_W = 2;

    // reset values of the configuration registers
    localparam logic [STEP_W-1:0] PERIOD_RST = STEP_W'(20);
    localparam logic [DUTY_W-1:0] OPEN_DUTY_RST = DUTY_W'(3);
    localparam logic [DUTY_W-1:0] CLOSE_DUTY_RST = DUTY_W'(2);

    typedef enum logic [1:0] {
        ACT_OPEN    = 2'd0,
        ACT_CLOSE   = 2'd1,
        ACT_BRAKE   = 2'd2,
        ACT_RELEASE = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_PERIOD = 2'd0,
        CFG_OPEN_DUTY  = 2'd1,
        CFG_CLOSE_DUTY = 2'd2
    } t_cfg_idx;

    // per-motor update control from the top level
    typedef struct packed {
        logic              tick;
        logic [STEP_W-1:0] step_next;
        logic              set;
        t_action           action;
        logic [DUTY_W-1:0] open_duty;
        logic [DUTY_W-1:0] close_duty;
    } t_motor_ctl;

    // visible state of one motor
    typedef struct packed {
        t_action action;
        logic    open_pin;
        logic    close_pin;
    } t_motor_state;

endpackage

// ----- rtl/hbsp_step.sv -----
// shared pwm step counter, advanced by tick items
module hbsp_step (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_tick,
    input  logic [hbsp_pkg::STEP_W-1:0]  i_period,
    output logic [hbsp_pkg::STEP_W-1:0]  o_step_next
);
    import hbsp_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W:0]   w_inc;

    // increment and wrap at the period (a period of zero keeps the count at zero)
    always_comb begin
        w_inc = {1'b0, r_step} + (STEP_W+1)'(1);
        if (w_inc >= {1'b0, i_period}) begin
            o_step_next = '0;
        end else begin
            o_step_next = w_inc[STEP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_tick) begin
            r_step <= o_step_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a tick either wraps to zero or moves the count up by one
    a_step_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick |=> (r_step == '0 || r_step == STEP_W'($past(r_step) + STEP_W'(1))))
        else $error("step counter moved by more than one");
    // the counter only moves on a tick
    a_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tick |=> $stable(r_step))
        else $error("step counter moved without a tick");
`endif

endmodule

// ----- rtl/hbsp_motor.sv -----
// action, duty and pin levels of one h-bridge motor
module hbsp_motor (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  hbsp_pkg::t_motor_ctl    i_ctl,
    output hbsp_pkg::t_motor_state  o_nxt
);
    import hbsp_pkg::*;

    t_action           r_action;
    logic [DUTY_W-1:0] r_duty;
    logic              r_open;
    logic              r_close;

    t_action           n_action;
    logic [DUTY_W-1:0] n_duty;
    logic              n_open;
    logic              n_close;

    // next motor state for a command or a tick
    always_comb begin
        n_action = r_action;
        n_duty   = r_duty;
        n_open   = r_open;
        n_close  = r_close;
        if (i_ctl.set) begin
            n_action = i_ctl.action;
            unique case (i_ctl.action)
                ACT_OPEN: begin
                    n_duty  = i_ctl.open_duty;
                    n_open  = 1'b0;
                    n_close = 1'b0;
                end
                ACT_CLOSE: begin
                    n_duty  = i_ctl.close_duty;
                    n_open  = 1'b0;
                    n_close = 1'b0;
                end
                ACT_BRAKE: begin
                    n_duty  = '0;
                    n_open  = 1'b1;
                    n_close = 1'b1;
                end
                default: begin
                    n_duty  = '0;
                    n_open  = 1'b0;
                    n_close = 1'b0;
                end
            endcase
        end else if (i_ctl.tick) begin
            // active pin: set at step zero for nonzero duty, clear when step meets duty
            if (r_action == ACT_OPEN) begin
                if (i_ctl.step_next == '0) begin
                    if (r_duty != '0) n_open = 1'b1;
                end else if (r_duty == i_ctl.step_next) begin
                    n_open = 1'b0;
                end
            end else if (r_action == ACT_CLOSE) begin
                if (i_ctl.step_next == '0) begin
                    if (r_duty != '0) n_close = 1'b1;
                end else if (r_duty == i_ctl.step_next) begin
                    n_close = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_action <= ACT_RELEASE;
            r_duty   <= '0;
            r_open   <= 1'b0;
            r_close  <= 1'b0;
        end else begin
            r_action <= n_action;
            r_duty   <= n_duty;
            r_open   <= n_open;
            r_close  <= n_close;
        end
    end

    assign o_nxt.action    = n_action;
    assign o_nxt.open_pin  = n_open;
    assign o_nxt.close_pin = n_close;

`ifndef NO_ASSERTIONS
    // braking drives both pins high
    a_brake_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_action == ACT_BRAKE |-> (r_open && r_close))
        else $error("brake without both pins high");
    // a released motor keeps both pins low and zero duty
    a_release_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_action == ACT_RELEASE |-> (!r_open && !r_close && r_duty == '0))
        else $error("released motor has a pin or duty set");
    // an opening motor never drives its close pin
    a_open_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_action == ACT_OPEN |-> !r_close)
        else $error("opening motor drives close pin");
`endif

endmodule

// ----- rtl/hbridge_soft_pwm_driver.sv -----
// top level of the h-bridge soft pwm driver
//
// Usage: items arrive on the s_axis channel. s_axis_tuser is the kind:
// 0 sets the action of the motor in tdata[0] to tdata[2:1] (open, close,
// brake, release), 1 is a pwm tick that advances the shared step counter.
// Every item gives exactly one result on m_axis: the open pins, close pins
// and the actions of all motors after the item.
// An accepted item sits in the input register, and the edge that moves it on
// both updates the motor state and loads the result register, which drives
// m_axis_tvalid. Throughput is one item per clock; the input register and the
// result register are both full-rate, so s_axis_tready stays high while
// m_axis_tready is high or the result register is empty.
// When the receiver stalls, the result holds and one more item waits in the
// input register, after which s_axis_tready drops.
// Configuration registers (period, open duty, close duty) are written on the
// cfg channel, which is always ready; write them only while the block is idle.
// Synchronous active-low reset returns all motors to release with pins low,
// the step counter to zero and registers to period 20, duties 3 and 2.
module hbridge_soft_pwm_driver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input item
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // motor_sel[0], action[2:1], zero
    input  logic                            s_axis_tuser,  // cmd[0]
    // result item
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // open_pins[1:0], close_pins[3:2],
                                                           // actions_now[7:4]
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hbsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hbsp_pkg::DUTY_W-1:0]     i_cfg_data
);
    import hbsp_pkg::*;

    // configuration registers
    logic [STEP_W-1:0] r_period;
    logic [DUTY_W-1:0] r_open_duty;
    logic [DUTY_W-1:0] r_close_duty;

    // input register
    logic    r_in_valid;
    logic    r_in_cmd;
    logic    r_in_sel;
    t_action r_in_action;

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_data;

    logic              w_advance;
    logic              w_tick;
    logic [STEP_W-1:0] w_step_next;
    t_motor_ctl        w_ctl [NUM_MOTORS];
    t_motor_state      w_nxt [NUM_MOTORS];
    logic [7:0]        w_result;

    assign o_cfg_ready = 1'b1;

    // configuration register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= PERIOD_RST;
            r_open_duty  <= OPEN_DUTY_RST;
            r_close_duty <= CLOSE_DUTY_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PWM_PERIOD: r_period     <= i_cfg_data;
                CFG_OPEN_DUTY:  r_open_duty  <= i_cfg_data;
                CFG_CLOSE_DUTY: r_close_duty <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item moves from input register to result register
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_tick        = w_advance && r_in_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd    <= s_axis_tuser;
            r_in_sel    <= s_axis_tdata[0];
            r_in_action <= t_action'(s_axis_tdata[2:1]);
        end
    end

    hbsp_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (w_tick),
        .i_period    (r_period),
        .o_step_next (w_step_next)
    );

    // one motor channel each
    for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_motor
        assign w_ctl[g].tick       = w_tick;
        assign w_ctl[g].step_next  = w_step_next;
        assign w_ctl[g].set        = w_advance && !r_in_cmd && (int'(r_in_sel) == g);
        assign w_ctl[g].action     = r_in_action;
        assign w_ctl[g].open_duty  = r_open_duty;
        assign w_ctl[g].close_duty = r_close_duty;

        hbsp_motor u_motor (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .o_nxt   (w_nxt[g])
        );
    end

    // pack the result, motors beyond the field widths are dropped
    always_comb begin
        w_result = '0;
        for (int m = 0; m < OUT_MOTORS; m++) begin
            w_result[m]         = w_nxt[m].open_pin;
            w_result[2 + m]     = w_nxt[m].close_pin;
            w_result[4 + 2*m +: 2] = w_nxt[m].action;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    // a held item always lands in the result register on the next cycle
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> m_axis_tvalid)
        else $error("advanced item did not reach the result register");
    // the input register only blocks while a result is stalled
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without a stalled result");
    // a braking action shown for motor 0 always comes with both its pins high
    a_out_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[5:4] == ACT_BRAKE)
            |-> (m_axis_tdata[0] && m_axis_tdata[2]))
        else $error("result shows brake without both pins high");
`endif

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the h-bridge soft pwm driver
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hbsp_pkg::*;

    // item kinds carried on s_axis_tuser
    localparam bit CMD_ACTION = 1'b0;
    localparam bit CMD_TICK   = 1'b1;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int RANDOM_PHASES   = 8;
    localparam int CYCLE_LIMIT     = 400000;

    // one result: pin levels and actions of every motor
    typedef struct {
        logic [1:0] open_pins;
        logic [1:0] close_pins;
        logic [3:0] actions_now;
    } t_pin_state;

    // tracks motor state and the queue of pin states still to come out
    class t_pin_tracker;
        logic [STEP_W-1:0] period_r;
        logic [DUTY_W-1:0] open_duty_r;
        logic [DUTY_W-1:0] close_duty_r;
        logic [STEP_W-1:0] step_q;
        t_action           act_q   [NUM_MOTORS];
        logic [DUTY_W-1:0] duty_q  [NUM_MOTORS];
        bit                open_lv [NUM_MOTORS];
        bit                close_lv[NUM_MOTORS];
        t_pin_state        expected_pins[$];
        int                errors;
        int                checked;

        function void clear();
            period_r     = PERIOD_RST;
            open_duty_r  = OPEN_DUTY_RST;
            close_duty_r = CLOSE_DUTY_RST;
            step_q       = '0;
            for (int m = 0; m < NUM_MOTORS; m++) begin
                act_q[m]    = ACT_RELEASE;
                duty_q[m]   = '0;
                open_lv[m]  = 1'b0;
                close_lv[m] = 1'b0;
            end
            expected_pins.delete();
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [DUTY_W-1:0] val);
            case (idx)
                CFG_PWM_PERIOD: period_r = val;
                CFG_OPEN_DUTY:  open_duty_r = val;
                CFG_CLOSE_DUTY: close_duty_r = val;
                default: ;
            endcase
        endfunction

        // advance the model by one accepted item and queue its result
        function void note_item(bit cmd, bit sel, t_action act);
            int         nxt;
            bit         lvl;
            t_pin_state res;
            if (cmd == CMD_TICK) begin
                nxt = int'(step_q) + 1;
                if (nxt >= int'(period_r)) nxt = 0;
                step_q = STEP_W'(nxt);
                for (int m = 0; m < NUM_MOTORS; m++) begin
                    if (act_q[m] == ACT_OPEN || act_q[m] == ACT_CLOSE) begin
                        lvl = (act_q[m] == ACT_OPEN) ? open_lv[m] : close_lv[m];
                        if (step_q == 0) begin
                            if (duty_q[m] != 0) lvl = 1'b1;
                        end else if (duty_q[m] == step_q) begin
                            lvl = 1'b0;
                        end
                        if (act_q[m] == ACT_OPEN) open_lv[m] = lvl;
                        else close_lv[m] = lvl;
                    end
                end
            end else if (int'(sel) < NUM_MOTORS) begin
                case (act)
                    ACT_OPEN:  duty_q[sel] = open_duty_r;
                    ACT_CLOSE: duty_q[sel] = close_duty_r;
                    default:   duty_q[sel] = '0;
                endcase
                open_lv[sel]  = (act == ACT_BRAKE);
                close_lv[sel] = (act == ACT_BRAKE);
                act_q[sel]    = act;
            end
            res.open_pins   = '0;
            res.close_pins  = '0;
            res.actions_now = '0;
            for (int m = 0; m < OUT_MOTORS; m++) begin
                res.open_pins[m]          = open_lv[m];
                res.close_pins[m]         = close_lv[m];
                res.actions_now[2*m +: 2] = act_q[m];
            end
            expected_pins.push_back(res);
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(logic [7:0] data);
            t_pin_state want;
            if (expected_pins.size() == 0) begin
                $display("%0t: result %h with nothing expected", $time, data);
                errors++;
                return;
            end
            want = expected_pins.pop_front();
            checked++;
            if (data[1:0] !== want.open_pins) begin
                $display("%0t: open_pins expected %b actual %b",
                         $time, want.open_pins, data[1:0]);
                errors++;
            end
            if (data[3:2] !== want.close_pins) begin
                $display("%0t: close_pins expected %b actual %b",
                         $time, want.close_pins, data[3:2]);
                errors++;
            end
            if (data[7:4] !== want.actions_now) begin
                $display("%0t: actions_now expected %b actual %b",
                         $time, want.actions_now, data[7:4]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DUTY_W-1:0]    i_cfg_data;

    t_pin_tracker   pins_model;
    bit             calm;
    bit             running;
    int             items_sent;
    int             settings_used;
    int             cycle_count;

    hbridge_soft_pwm_driver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: timeout after %0d cycles", cycle_count);
        $display("tb: failure");
        $finish;
    end

    // result side: random stall bursts until the calm tail
    initial begin
        m_axis_tready = 1'b0;
        wait (running);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
            end
        end
    end

    // check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            pins_model.check_result(m_axis_tdata);
    end

    // one item transfer, with an occasional idle burst in front
    task automatic send_item(bit cmd, bit sel, t_action act);
        if (!calm && $urandom_range(0, 9) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {5'b0, act, sel};
        do @(posedge i_clk); while (!s_axis_tready);
        pins_model.note_item(cmd, sel, act);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 1'($urandom_range(0, 1)), t_action'($urandom_range(0, 3)));
    endtask

    // stop sending and wait until every result is out
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pins_model.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [DUTY_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        pins_model.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_regs(int period, int o_duty, int c_duty);
        write_reg(CFG_PWM_PERIOD, DUTY_W'(period));
        write_reg(CFG_OPEN_DUTY, DUTY_W'(o_duty));
        write_reg(CFG_CLOSE_DUTY, DUTY_W'(c_duty));
        settings_used++;
    endtask

    // mostly ticks, commands weighted toward open and close
    task automatic send_random_item();
        int      pick;
        t_action act;
        if ($urandom_range(0, 3) != 0) begin
            send_tick();
        end else begin
            pick = $urandom_range(0, 9);
            act  = (pick < 4) ? ACT_OPEN : (pick < 8) ? ACT_CLOSE :
                   (pick == 8) ? ACT_BRAKE : ACT_RELEASE;
            send_item(CMD_ACTION, 1'($urandom_range(0, 1)), act);
        end
    endtask

    initial begin
        int period;
        pins_model    = new();
        pins_model.clear();
        calm          = 1'b0;
        running       = 1'b0;
        items_sent    = 0;
        settings_used = 1;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_PWM_PERIOD;
        i_cfg_data    = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        running = 1'b1;

        // register values out of reset
        send_item(CMD_ACTION, 1'b0, ACT_OPEN);
        send_item(CMD_ACTION, 1'b1, ACT_CLOSE);
        send_tick();
        send_tick();
        drain();

        // short period, close duty above the period so its pin stays high
        set_regs(3, 2, 63);
        send_item(CMD_ACTION, 1'b0, ACT_OPEN);
        send_item(CMD_ACTION, 1'b1, ACT_CLOSE);
        repeat (6) send_tick();
        send_item(CMD_ACTION, 1'b0, ACT_BRAKE);
        send_tick();
        send_item(CMD_ACTION, 1'b1, ACT_RELEASE);
        send_tick();
        send_item(CMD_ACTION, 1'b0, ACT_CLOSE);
        send_item(CMD_ACTION, 1'b1, ACT_OPEN);
        repeat (3) send_tick();
        drain();

        // period of zero with the counter left above it, zero open duty
        set_regs(0, 0, 5);
        send_item(CMD_ACTION, 1'b0, ACT_OPEN);
        send_item(CMD_ACTION, 1'b1, ACT_CLOSE);
        repeat (3) send_tick();
        drain();

        // random phases, each under its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_regs(63, 63, 0);
                1: set_regs(1, 0, 63);
                2: set_regs(0, $urandom_range(0, 3), $urandom_range(0, 3));
                default: begin
                    period = $urandom_range(2, 12);
                    set_regs(period, $urandom_range(0, period + 2),
                             $urandom_range(0, period + 2));
                end
            endcase
            if (p == RANDOM_PHASES - 1) calm = 1'b1;
            repeat (ITEMS_PER_PHASE) send_random_item();
            drain();
        end

        repeat (10) @(posedge i_clk);
        $display("tb: %0d items under %0d register settings, %0d results checked",
                 items_sent, settings_used, pins_model.checked);
        $display("tb: covered open, close, brake, release, pwm wrap and duty extremes");
        if (pins_model.errors == 0 && pins_model.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches, %0d results missing",
                     pins_model.errors, pins_model.pending());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
